// ===== rtl/dmt_pkg.sv =====
// ----------------------------------------------------------------------------
// dmt_pkg: shared types and constants of the distinct magnitude table
// Widths, payload structs and small helper functions used by every file.
// ----------------------------------------------------------------------------
package dmt_pkg;

    // Table geometry and component width.
    localparam int TABLE_DEPTH    = 16;
    localparam int COMPONENT_BITS = 24;

    // Fixed field widths of the channels.
    localparam int FIELD_W       = 24;
    localparam int MAG_W         = 24;
    localparam int TOL_W         = 16;
    localparam int FRAC_W        = 16;
    localparam int MATCH_IDX_W   = 6;
    localparam int ENTRY_CNT_W   = 7;

    // Derived internal widths.
    localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W     = 2 * COMPONENT_BITS + 2;
    localparam int ROOT_W    = COMPONENT_BITS + 1;
    localparam int REM_W     = COMPONENT_BITS + 4;
    localparam int SQ_CNT_W  = $clog2(COMPONENT_BITS);
    localparam int RT_CNT_W  = $clog2(ROOT_W);
    localparam int PROD_W    = MAG_W + TOL_W;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(655);
    localparam logic [MAG_W-1:0] MAG_MAX   = {MAG_W{1'b1}};

    // One input beat.
    typedef struct packed {
        logic                      start_set;
        logic signed [FIELD_W-1:0] comp_x;
        logic signed [FIELD_W-1:0] comp_y;
        logic signed [FIELD_W-1:0] comp_z;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic [MAG_W-1:0]       magnitude;
        logic                   was_zero;
        logic                   is_new;
        logic                   dropped;
        logic [MATCH_IDX_W-1:0] match_index;
        logic [ENTRY_CNT_W-1:0] entry_count;
        logic [MAG_W-1:0]       max_magnitude;
    } t_out_item;

    // Request from the sequencer to the table unit.
    typedef struct packed {
        logic             valid;
        logic [MAG_W-1:0] mag;
    } t_scan_req;

    // Response of the table unit, valid for one cycle when done is high.
    typedef struct packed {
        logic             done;
        logic             was_zero;
        logic             is_new;
        logic             dropped;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] count;
        logic [MAG_W-1:0] max;
    } t_scan_rsp;

    // Absolute value of the low COMPONENT_BITS bits of a field, sign extended.
    function automatic logic [COMPONENT_BITS-1:0] comp_abs(
        input logic signed [FIELD_W-1:0] f
    );
        logic signed [COMPONENT_BITS-1:0] v;
        logic [COMPONENT_BITS-1:0]        u;
        v = COMPONENT_BITS'(f);
        u = v;
        return u[COMPONENT_BITS-1] ? (~u + 1'b1) : u;
    endfunction

    // Saturate a root to the magnitude width.
    function automatic logic [MAG_W-1:0] sat_mag(input logic [ROOT_W-1:0] root);
        return (root > ROOT_W'(MAG_MAX)) ? MAG_MAX : MAG_W'(root);
    endfunction

endpackage

// ===== rtl/dmt_if.sv =====
// ----------------------------------------------------------------------------
// dmt_if: valid/ready channel interfaces of the distinct magnitude table
// Input vector channel, result channel and tolerance write channel.
// ----------------------------------------------------------------------------

// Input vector channel.
interface dmt_in_if;
    logic              valid;
    logic              ready;
    dmt_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel.
interface dmt_out_if;
    logic               valid;
    logic               ready;
    dmt_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Tolerance register write channel.
interface dmt_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dmt_pkg::TOL_W-1:0]    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dmt_sumsq.sv =====
// ----------------------------------------------------------------------------
// dmt_sumsq: bit-serial sum of squares
// Squares the three component magnitudes MSB first, one multiplier bit of
// each per cycle, and accumulates the three partial products together.
// ----------------------------------------------------------------------------
module dmt_sumsq (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [dmt_pkg::FIELD_W-1:0]    i_x,
    input  logic signed [dmt_pkg::FIELD_W-1:0]    i_y,
    input  logic signed [dmt_pkg::FIELD_W-1:0]    i_z,
    output logic                                  o_done,
    output logic [dmt_pkg::SUM_W-1:0]             o_sum
);

    localparam int CB = dmt_pkg::COMPONENT_BITS;
    localparam int SW = dmt_pkg::SUM_W;

    logic [CB-1:0]                 r_ax, r_ay, r_az;
    logic [CB-1:0]                 r_bx, r_by, r_bz;
    logic [SW-1:0]                 r_acc;
    logic [SW-1:0]                 n_acc;
    logic [dmt_pkg::SQ_CNT_W-1:0]  r_cnt;
    logic                          r_busy;
    logic                          r_done;

    // Shift-add step: double the sum and add each multiplicand whose
    // multiplier bit is set at the top of its shift register.
    always_comb begin
        n_acc = {r_acc[SW-2:0], 1'b0}
              + (r_bx[CB-1] ? SW'(r_ax) : '0)
              + (r_by[CB-1] ? SW'(r_ay) : '0)
              + (r_bz[CB-1] ? SW'(r_az) : '0);
    end

    // Control: run one step per multiplier bit after a start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= dmt_pkg::SQ_CNT_W'(CB - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: operand and multiplier shift registers, accumulator.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ax  <= dmt_pkg::comp_abs(i_x);
            r_ay  <= dmt_pkg::comp_abs(i_y);
            r_az  <= dmt_pkg::comp_abs(i_z);
            r_bx  <= dmt_pkg::comp_abs(i_x);
            r_by  <= dmt_pkg::comp_abs(i_y);
            r_bz  <= dmt_pkg::comp_abs(i_z);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_bx  <= {r_bx[CB-2:0], 1'b0};
            r_by  <= {r_by[CB-2:0], 1'b0};
            r_bz  <= {r_bz[CB-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;

endmodule

// ===== rtl/dmt_isqrt.sv =====
// ----------------------------------------------------------------------------
// dmt_isqrt: digit-serial integer square root
// Restoring root extraction that consumes two radicand bits and produces
// one root bit per cycle, giving the floor of the square root.
// ----------------------------------------------------------------------------
module dmt_isqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dmt_pkg::SUM_W-1:0]      i_n,
    output logic                           o_done,
    output logic [dmt_pkg::ROOT_W-1:0]     o_root
);

    localparam int SW = dmt_pkg::SUM_W;
    localparam int RW = dmt_pkg::ROOT_W;
    localparam int MW = dmt_pkg::REM_W;

    logic [SW-1:0]                 r_n;
    logic [MW-1:0]                 r_rem;
    logic [RW-1:0]                 r_root;
    logic [dmt_pkg::RT_CNT_W-1:0]  r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [MW-1:0]                 n_rem_sh;
    logic [MW-1:0]                 n_trial;
    logic                          n_take;

    // One root digit: bring down two bits and try to subtract 4*root+1.
    // The remainder never exceeds twice the partial root, so its top two
    // bits are zero before the shift.
    always_comb begin
        n_rem_sh = {r_rem[MW-3:0], r_n[SW-1:SW-2]};
        n_trial  = MW'({r_root, 2'b01});
        n_take   = (n_rem_sh >= n_trial);
    end

    // Control: one step per root bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= dmt_pkg::RT_CNT_W'(RW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: radicand shift register, remainder and root.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n    <= {r_n[SW-3:0], 2'b00};
            r_rem  <= n_take ? (n_rem_sh - n_trial) : n_rem_sh;
            r_root <= {r_root[RW-2:0], n_take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== rtl/dmt_table.sv =====
// ----------------------------------------------------------------------------
// dmt_table: table of distinct magnitudes
// Compares a magnitude with the stored entries one at a time by relative
// difference, appends it when unmatched and not full, and tracks the maximum.
// ----------------------------------------------------------------------------
module dmt_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic [dmt_pkg::TOL_W-1:0]     i_tol,
    input  dmt_pkg::t_scan_req            i_req,
    output dmt_pkg::t_scan_rsp            o_rsp
);

    localparam int DEPTH = dmt_pkg::TABLE_DEPTH;
    localparam int IW    = dmt_pkg::IDX_W;
    localparam int CW    = dmt_pkg::CNT_W;
    localparam int MGW   = dmt_pkg::MAG_W;

    typedef enum logic [4:0] {
        T_IDLE    = 5'b00001,
        T_READ    = 5'b00010,
        T_MUL     = 5'b00100,
        T_CMP     = 5'b01000,
        T_NOMATCH = 5'b10000
    } t_tstate;

    t_tstate                      r_state;
    logic [MGW-1:0]               r_mem [DEPTH];
    logic [CW-1:0]                r_count;
    logic [MGW-1:0]               r_max;
    logic [IW-1:0]                r_idx;
    logic [MGW-1:0]               r_mag;
    logic [MGW-1:0]               r_s;
    logic [dmt_pkg::PROD_W-1:0]   r_prod;
    logic [MGW-1:0]               r_diff;
    dmt_pkg::t_scan_rsp           r_rsp;
    logic                         n_match;
    logic                         n_last;

    // Relative test on the registered difference and product.
    always_comb begin
        n_match = ({r_diff, {dmt_pkg::FRAC_W{1'b0}}} < r_prod);
        n_last  = ((CW'(r_idx) + 1'b1) == r_count);
    end

    // Entry storage: one registered read, one write per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == T_READ) begin
            r_s <= r_mem[r_idx];
        end
        if (r_state == T_NOMATCH && r_count < CW'(DEPTH)) begin
            r_mem[r_count[IW-1:0]] <= r_mag;
        end
    end

    // Difference and tolerance product for the entry just read.
    always_ff @(posedge i_clk) begin
        if (r_state == T_MUL) begin
            r_prod <= i_tol * r_s;
            r_diff <= (r_mag > r_s) ? (r_mag - r_s) : (r_s - r_mag);
        end
        if (r_state == T_IDLE && i_req.valid) begin
            r_mag <= i_req.mag;
        end
    end

    // Scan sequencer, fill count and running maximum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_count <= '0;
            r_max   <= '0;
            r_idx   <= '0;
            r_rsp   <= '0;
        end else begin
            r_rsp.done <= 1'b0;
            unique case (r_state)
                T_IDLE: begin
                    if (i_clear) begin
                        r_count <= '0;
                        r_max   <= '0;
                    end
                    r_idx <= '0;
                    if (i_req.valid) begin
                        if (i_req.mag == '0) begin
                            r_rsp.done     <= 1'b1;
                            r_rsp.was_zero <= 1'b1;
                            r_rsp.is_new   <= 1'b0;
                            r_rsp.dropped  <= 1'b0;
                            r_rsp.idx      <= '0;
                            r_rsp.count    <= r_count;
                            r_rsp.max      <= r_max;
                        end else if (r_count == '0) begin
                            r_state <= T_NOMATCH;
                        end else begin
                            r_state <= T_READ;
                        end
                    end
                end
                T_READ: begin
                    r_state <= T_MUL;
                end
                T_MUL: begin
                    r_state <= T_CMP;
                end
                T_CMP: begin
                    if (n_match) begin
                        r_rsp.done     <= 1'b1;
                        r_rsp.was_zero <= 1'b0;
                        r_rsp.is_new   <= 1'b0;
                        r_rsp.dropped  <= 1'b0;
                        r_rsp.idx      <= r_idx;
                        r_rsp.count    <= r_count;
                        r_rsp.max      <= r_max;
                        r_state        <= T_IDLE;
                    end else if (n_last) begin
                        r_state <= T_NOMATCH;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= T_READ;
                    end
                end
                T_NOMATCH: begin
                    r_rsp.done     <= 1'b1;
                    r_rsp.was_zero <= 1'b0;
                    r_state        <= T_IDLE;
                    if (r_count < CW'(DEPTH)) begin
                        r_rsp.is_new  <= 1'b1;
                        r_rsp.dropped <= 1'b0;
                        r_rsp.idx     <= r_count[IW-1:0];
                        r_rsp.count   <= r_count + 1'b1;
                        r_rsp.max     <= (r_mag > r_max) ? r_mag : r_max;
                        r_count       <= r_count + 1'b1;
                        if (r_mag > r_max) begin
                            r_max <= r_mag;
                        end
                    end else begin
                        r_rsp.is_new  <= 1'b0;
                        r_rsp.dropped <= 1'b1;
                        r_rsp.idx     <= '0;
                        r_rsp.count   <= r_count;
                        r_rsp.max     <= r_max;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_rsp = r_rsp;

`ifndef ASSERT_OFF
    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("table fill count exceeds depth");

    // A response carries at most one of the outcome flags.
    a_rsp_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp.done |-> $onehot0({r_rsp.was_zero, r_rsp.is_new, r_rsp.dropped}))
        else $error("table response has conflicting outcome flags");

    // A drop is reported only against a full table.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp.done && r_rsp.dropped) |-> (r_rsp.count == CW'(DEPTH)))
        else $error("value dropped while table has room");
`endif

endmodule

// ===== rtl/distinct_magnitude_table_unit.sv =====
// ----------------------------------------------------------------------------
// distinct_magnitude_table_unit: table of distinct vector magnitudes
// Forms the integer magnitude of each input vector and reports whether it
// matches, extends or overflows a table of distinct magnitudes.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one vector beat (start_set and three signed components);
//   a beat is taken when valid and ready are both high. o_out returns one
//   result beat per vector. i_cfg writes the 16-bit relative tolerance and
//   is always ready; write it only while no vector is in flight.
// Processing:
//   The sum of squares is formed bit-serially and then the root one bit a
//   cycle. The table then compares stored entries one at a time, each through
//   its read, multiply and compare states, and appends an unmatched value in
//   the no-match state; the next vector is taken once the current one is
//   handed to the output register.
// Reset and stalls:
//   Reset empties the table, clears the maximum and sets the tolerance to
//   655. The output register holds a result until it is taken; while it is
//   full a new vector is still accepted and computed, and waits before the
//   table step until the output register is free.
// ----------------------------------------------------------------------------
module distinct_magnitude_table_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dmt_in_if.sink    i_in,
    dmt_out_if.source o_out,
    dmt_cfg_if.sink   i_cfg
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SUMSQ = 5'b00010,
        ST_ROOT  = 5'b00100,
        ST_HOLD  = 5'b01000,
        ST_TABLE = 5'b10000
    } t_state;

    t_state                          r_state;
    logic [dmt_pkg::TOL_W-1:0]       r_tol;
    logic [dmt_pkg::MAG_W-1:0]       r_mag;
    logic                            r_out_valid;
    dmt_pkg::t_out_item              r_out_data;
    logic                            n_in_take;
    logic                            sq_done;
    logic [dmt_pkg::SUM_W-1:0]       sq_sum;
    logic                            rt_done;
    logic [dmt_pkg::ROOT_W-1:0]      rt_root;
    dmt_pkg::t_scan_req              n_req;
    dmt_pkg::t_scan_rsp              tb_rsp;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign n_in_take   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= dmt_pkg::TOL_RESET;
        end else if (i_cfg.valid) begin
            r_tol <= i_cfg.data;
        end
    end

    // Serial squaring and root extraction.
    dmt_sumsq u_sumsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_in_take),
        .i_x     (i_in.data.comp_x),
        .i_y     (i_in.data.comp_y),
        .i_z     (i_in.data.comp_z),
        .o_done  (sq_done),
        .o_sum   (sq_sum)
    );

    dmt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_done),
        .i_n     (sq_sum),
        .o_done  (rt_done),
        .o_root  (rt_root)
    );

    // Table request is issued once the output register is free.
    always_comb begin
        n_req.valid = (r_state == ST_HOLD) && !r_out_valid;
        n_req.mag   = r_mag;
    end

    dmt_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (n_in_take && i_in.data.start_set),
        .i_tol   (r_tol),
        .i_req   (n_req),
        .o_rsp   (tb_rsp)
    );

    // Item sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (n_in_take) begin
                        r_state <= ST_SUMSQ;
                    end
                end
                ST_SUMSQ: begin
                    if (sq_done) begin
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (rt_done) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (!r_out_valid) begin
                        r_state <= ST_TABLE;
                    end
                end
                ST_TABLE: begin
                    if (tb_rsp.done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Saturated magnitude of the current item.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROOT && rt_done) begin
            r_mag <= dmt_pkg::sat_mag(rt_root);
        end
    end

    // Output register: filled from the table response, emptied by a beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tb_rsp.done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tb_rsp.done) begin
            r_out_data.magnitude     <= r_mag;
            r_out_data.was_zero      <= tb_rsp.was_zero;
            r_out_data.is_new        <= tb_rsp.is_new;
            r_out_data.dropped       <= tb_rsp.dropped;
            r_out_data.match_index   <= dmt_pkg::MATCH_IDX_W'(tb_rsp.idx);
            r_out_data.entry_count   <= dmt_pkg::ENTRY_CNT_W'(tb_rsp.count);
            r_out_data.max_magnitude <= tb_rsp.max;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

`ifndef ASSERT_OFF
    // A table response never lands on a result still waiting to be taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tb_rsp.done |-> !r_out_valid)
        else $error("table response would overwrite pending result");

    // Table responses only come while the sequencer waits for one.
    a_rsp_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tb_rsp.done |-> (r_state == ST_TABLE))
        else $error("unexpected table response");

    // A zero magnitude is reported as skipped, with index zero.
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.was_zero) |->
            (r_out_data.magnitude == '0 && r_out_data.match_index == '0))
        else $error("skipped result with nonzero magnitude or index");
`endif

endmodule
